FILE: src/dht_rx_pkg.sv
// dht_rx_pkg: shared codes, pulse windows and types for the dht pulse width receiver
// no dependencies; imported by the interfaces and all modules in src
package dht_rx_pkg;

  // event codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_TIMER = 2'd1;
  localparam logic [1:0] CMD_EDGE  = 2'd2;

  // status codes
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_BAD_SUM = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_WINDOW  = 3'd4;

  // phase codes
  localparam logic [2:0] PH_START_PULSE = 3'd0;
  localparam logic [2:0] PH_START_PAUSE = 3'd1;
  localparam logic [2:0] PH_PRESENCE0   = 3'd2;
  localparam logic [2:0] PH_PRESENCE1   = 3'd3;
  localparam logic [2:0] PH_SYNC        = 3'd4;
  localparam logic [2:0] PH_DATA        = 3'd5;

  // pulse windows in microseconds
  localparam logic [7:0] START_PAUSE_MIN = 8'd5;   // inclusive
  localparam logic [7:0] START_PAUSE_MAX = 8'd70;  // inclusive
  localparam logic [7:0] PRESENCE_LO     = 8'd50;  // exclusive
  localparam logic [7:0] PRESENCE_HI     = 8'd100; // exclusive
  localparam logic [7:0] SYNC_LO         = 8'd30;  // exclusive
  localparam logic [7:0] SYNC_HI         = 8'd70;  // exclusive
  localparam logic [7:0] DATA_LO         = 8'd15;  // exclusive
  localparam logic [7:0] DATA_HI         = 8'd90;  // exclusive
  localparam logic [7:0] DATA_ONE_MIN    = 8'd45;  // longer than this is a one

  // conversion of the reading
  localparam logic [7:0]  MAG_MASK  = 8'h7F;
  localparam logic [7:0]  SIGN_MASK = 8'h80;
  localparam logic [15:0] DHT11_SCALE = 16'd10;

  // number of data bytes ahead of the checksum
  localparam logic [2:0] DATA_BYTES = 3'd4;

  // the four data bytes of a reading
  typedef logic [3:0][7:0] dht_bytes_t;

  // converted values handed back by the decoder
  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic        [15:0] humidity_tenths;
  } dht_values_t;

endpackage

FILE: src/dht_rx_if.sv
// dht_rx_in_if and dht_rx_out_if: valid/ready channels for events and results
// depends on dht_rx_pkg
interface dht_rx_in_if import dht_rx_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] elapsed_us;

  modport source (output valid, output cmd, output elapsed_us, input ready);
  modport sink   (input valid, input cmd, input elapsed_us, output ready);
endinterface

interface dht_rx_out_if import dht_rx_pkg::*; ();
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic        [2:0]  failed_phase;
  logic signed [15:0] temperature_tenths;
  logic        [15:0] humidity_tenths;

  modport source (output valid, output status, output failed_phase,
                  output temperature_tenths, output humidity_tenths, input ready);
  modport sink   (input valid, input status, input failed_phase,
                  input temperature_tenths, input humidity_tenths, output ready);
endinterface

FILE: src/dht_rx_decode.sv
// dht_rx_decode: turns the four data bytes into temperature and humidity in tenths
// depends on dht_rx_pkg; used by dht_pulse_width_receiver
module dht_rx_decode import dht_rx_pkg::*; (
  input  dht_bytes_t  bytes,
  output dht_values_t values
);

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] mag;

  assign b0 = bytes[0];
  assign b1 = bytes[1];
  assign b2 = bytes[2];
  assign b3 = bytes[3];
  assign mag = {b2 & MAG_MASK, b3};

  // dht11 when the fraction bytes are zero, else dht22 sign-magnitude
  always_comb begin
    if (b1 == 8'd0 && b3 == 8'd0) begin
      values.temperature_tenths = signed'({8'd0, b2} * DHT11_SCALE);
      values.humidity_tenths    = {8'd0, b0} * DHT11_SCALE;
    end else begin
      if ((b2 & SIGN_MASK) != 8'd0) begin
        values.temperature_tenths = signed'(16'd0 - mag);
      end else begin
        values.temperature_tenths = signed'(mag);
      end
      values.humidity_tenths = {b0, b1};
    end
  end

endmodule

FILE: src/dht_pulse_width_receiver.sv
// dht_pulse_width_receiver: single-wire dht11/dht22 reply checker and decoder
// output: each event transfer writes its result into the output register
// throughput: one event per cycle; a new event is taken while the result register
//   is empty or being drained in the same cycle
// reset: synchronous active-low rst_n clears phase, outcome and counters; the
//   data byte store is not cleared and is always written before a ready result
// depends on dht_rx_pkg, dht_rx_in_if, dht_rx_out_if, dht_rx_decode
module dht_pulse_width_receiver import dht_rx_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  dht_rx_in_if.sink    in_ch,
  dht_rx_out_if.source out_ch
);

  // receiver state
  logic [2:0] phase_r, phase_nxt;
  logic [2:0] outcome_r, outcome_nxt;
  logic [2:0] bad_phase_r, bad_phase_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic [2:0] byte_idx_r, byte_idx_nxt;
  logic [7:0] shift_byte_r, shift_byte_nxt;
  logic [7:0] byte_sum_r, byte_sum_nxt;
  dht_bytes_t bytes_r;
  logic       byte_wr;

  // output register
  logic               out_valid_r;
  logic        [2:0]  status_r;
  logic        [2:0]  failed_phase_r;
  logic signed [15:0] temp_r;
  logic        [15:0] hum_r;

  logic        in_xfer;
  logic [7:0]  t;
  logic [7:0]  shifted;
  dht_values_t values;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign t           = in_ch.elapsed_us;
  assign shifted     = {shift_byte_r[6:0], (t > DATA_ONE_MIN)};

  // next state for one event
  always_comb begin
    phase_nxt      = phase_r;
    outcome_nxt    = outcome_r;
    bad_phase_nxt  = bad_phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    byte_idx_nxt   = byte_idx_r;
    shift_byte_nxt = shift_byte_r;
    byte_sum_nxt   = byte_sum_r;
    byte_wr        = 1'b0;
    if (in_ch.cmd == CMD_START) begin
      phase_nxt     = PH_START_PULSE;
      outcome_nxt   = ST_BUSY;
      bad_phase_nxt = PH_START_PULSE;
    end else if (outcome_r == ST_BUSY) begin
      if (in_ch.cmd == CMD_TIMER) begin
        if (phase_r == PH_START_PULSE) begin
          phase_nxt = PH_START_PAUSE;
        end else begin
          outcome_nxt = ST_TIMEOUT;
        end
      end else if (in_ch.cmd == CMD_EDGE) begin
        // pulse width checks; any miss records the phase
        bad_phase_nxt = phase_r;
        outcome_nxt   = ST_WINDOW;
        case (phase_r)
          PH_START_PAUSE: begin
            if (t >= START_PAUSE_MIN && t <= START_PAUSE_MAX) begin
              bad_phase_nxt = bad_phase_r;
              outcome_nxt   = outcome_r;
              phase_nxt     = PH_PRESENCE0;
              bit_cnt_nxt   = 3'd0;
              byte_idx_nxt  = 3'd0;
              byte_sum_nxt  = 8'd0;
            end
          end
          PH_PRESENCE0, PH_PRESENCE1: begin
            if (t > PRESENCE_LO && t < PRESENCE_HI) begin
              bad_phase_nxt = bad_phase_r;
              outcome_nxt   = outcome_r;
              phase_nxt     = phase_r + 3'd1;
            end
          end
          PH_SYNC: begin
            if (t > SYNC_LO && t < SYNC_HI) begin
              bad_phase_nxt = bad_phase_r;
              outcome_nxt   = outcome_r;
              phase_nxt     = PH_DATA;
            end
          end
          PH_DATA: begin
            if (t > DATA_LO && t < DATA_HI) begin
              bad_phase_nxt  = bad_phase_r;
              outcome_nxt    = outcome_r;
              shift_byte_nxt = shifted;
              bit_cnt_nxt    = bit_cnt_r + 3'd1;
              phase_nxt      = PH_SYNC;
              // byte complete: store a data byte or check the checksum
              if (bit_cnt_r == 3'd7) begin
                if (byte_idx_r >= DATA_BYTES) begin
                  outcome_nxt = (byte_sum_r == shifted) ? ST_READY : ST_BAD_SUM;
                  phase_nxt   = phase_r;
                end else begin
                  byte_wr      = 1'b1;
                  byte_sum_nxt = byte_sum_r + shifted;
                  byte_idx_nxt = byte_idx_r + 3'd1;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START_PULSE;
      outcome_r    <= ST_BUSY;
      bad_phase_r  <= PH_START_PULSE;
      bit_cnt_r    <= 3'd0;
      byte_idx_r   <= 3'd0;
      shift_byte_r <= 8'd0;
      byte_sum_r   <= 8'd0;
    end else if (in_xfer) begin
      phase_r      <= phase_nxt;
      outcome_r    <= outcome_nxt;
      bad_phase_r  <= bad_phase_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      byte_idx_r   <= byte_idx_nxt;
      shift_byte_r <= shift_byte_nxt;
      byte_sum_r   <= byte_sum_nxt;
    end
  end

  // data byte store, no reset
  always_ff @(posedge clk) begin
    if (in_xfer && byte_wr) begin
      bytes_r[byte_idx_r[1:0]] <= shifted;
    end
  end

  dht_rx_decode u_decode (
    .bytes  (bytes_r),
    .values (values)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r       <= outcome_nxt;
      failed_phase_r <= (outcome_nxt == ST_WINDOW) ? bad_phase_nxt : 3'd0;
      temp_r         <= (outcome_nxt == ST_READY) ? values.temperature_tenths : 16'sd0;
      hum_r          <= (outcome_nxt == ST_READY) ? values.humidity_tenths : 16'd0;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = status_r;
  assign out_ch.failed_phase       = failed_phase_r;
  assign out_ch.temperature_tenths = temp_r;
  assign out_ch.humidity_tenths    = hum_r;

  // a ready outcome only after all bytes and the checksum were taken
  a_ready_done: assert property (@(posedge clk) disable iff (!rst_n)
    (outcome_r == ST_READY) |-> (phase_r == PH_DATA && byte_idx_r == DATA_BYTES))
    else $error("ready outcome before reading complete");

  // a failed phase is only kept for a window failure
  a_bad_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (outcome_r != ST_WINDOW) |-> (bad_phase_r == PH_START_PULSE))
    else $error("bad phase set without window failure");

  // finished conversions ignore every event but start
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && outcome_r != ST_BUSY && in_ch.cmd != CMD_START)
      |=> ($stable(phase_r) && $stable(outcome_r) && $stable(byte_idx_r)))
    else $error("state changed after completion");

  // values read zero unless ready
  a_zero_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_READY) |-> (temp_r == 16'sd0 && hum_r == 16'd0))
    else $error("values nonzero without ready status");

  // byte index never runs past the checksum
  a_byte_idx: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r <= DATA_BYTES)
    else $error("byte index overflow");

endmodule
